// ===== hw/rtl/cltok_pkg.sv =====
// Shared constants, character codes and types of the command line tokenizer.
package cltok_pkg;

  // Line and token limits
  localparam int MAX_LINE   = 99;
  localparam int NAME_BYTES = 16;
  localparam int ARG_SLOTS  = 7;

  // Result layout (fixed by the result fields)
  localparam int NAME_LANES = 16;
  localparam int ARG_LANES  = 7;

  // Widths of the line state
  localparam int LEN_W     = $clog2(MAX_LINE);
  localparam int NLEN_W    = $clog2(NAME_BYTES + 1);
  localparam int TOK_W     = 4;
  localparam int ARG_IDX_W = 3;
  localparam int ACC_W     = 32;
  localparam int ACC_EXT_W = 36;

  // Accumulator saturation and range limits
  localparam logic [ACC_W-1:0] ACC_CAP   = 32'd2147483649;
  localparam logic [ACC_W-1:0] POS_LIMIT = 32'd2147483647;
  localparam logic [ACC_W-1:0] NEG_LIMIT = 32'd2147483648;
  localparam logic [TOK_W-1:0] TOK_MAX   = 4'd15;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SPACING = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_LENGTH  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef logic [1:0] status_t;

  // Commands to the number parser
  typedef struct packed {
    logic feed;   // argument character for the current token
    logic close;  // token ends (space or newline)
  } num_cmd_t;

  // View of the token being parsed
  typedef struct packed {
    logic             live;       // token has started
    logic             range_err;  // magnitude beyond the signed limit
    logic [ACC_W-1:0] value;      // two's complement value
  } num_res_t;

endpackage

// ===== hw/rtl/cltok_in_if.sv =====
// Byte channel carrying one text byte per transaction.
interface cltok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== hw/rtl/cltok_out_if.sv =====
// Result channel carrying one parsed command line per transaction.
interface cltok_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [63:0]        name_low;
  logic [63:0]        name_high;
  logic [2:0]         arg_count;
  logic signed [31:0] arg0;
  logic signed [31:0] arg1;
  logic signed [31:0] arg2;
  logic signed [31:0] arg3;
  logic signed [31:0] arg4;
  logic signed [31:0] arg5;
  logic signed [31:0] arg6;

  modport source (output valid, output status, output name_low, output name_high,
                  output arg_count, output arg0, output arg1, output arg2,
                  output arg3, output arg4, output arg5, output arg6,
                  input ready);
  modport sink   (input valid, input status, input name_low, input name_high,
                  input arg_count, input arg0, input arg1, input arg2,
                  input arg3, input arg4, input arg5, input arg6,
                  output ready);
endinterface

// ===== hw/rtl/cltok_num.sv =====
// Signed decimal argument parser: sign, saturating magnitude and digit-run state.
module cltok_num import cltok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  num_cmd_t   cmd,
  input  logic [7:0] char_in,
  output num_res_t   res
);

  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 started_r, started_nxt;
  logic                 neg_r, neg_nxt;
  logic                 dead_r, dead_nxt;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [ACC_EXT_W-1:0] prod;
  logic                 is_digit;
  logic                 is_sign;

  // Current token view
  always_comb begin
    res.live      = started_r;
    res.range_err = started_r && (acc_r > (neg_r ? NEG_LIMIT : POS_LIMIT));
    res.value     = neg_r ? (ACC_W'(0) - acc_r) : acc_r;
  end

  // acc * 10 + digit, saturated
  assign acc_ext  = ACC_EXT_W'(acc_r);
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_W'(char_in[3:0]);
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_sign  = !started_r && ((char_in == CH_PLUS) || (char_in == CH_MINUS));

  // Next token state
  always_comb begin
    acc_nxt     = acc_r;
    started_nxt = started_r;
    neg_nxt     = neg_r;
    dead_nxt    = dead_r;
    if (cmd.close) begin
      acc_nxt     = '0;
      started_nxt = 1'b0;
      neg_nxt     = 1'b0;
      dead_nxt    = 1'b0;
    end else if (cmd.feed) begin
      started_nxt = 1'b1;
      if (is_sign) begin
        neg_nxt = (char_in == CH_MINUS);
      end else if (!dead_r && is_digit) begin
        acc_nxt = (prod > ACC_EXT_W'(ACC_CAP)) ? ACC_CAP : prod[ACC_W-1:0];
      end else begin
        dead_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      started_r <= 1'b0;
      neg_r     <= 1'b0;
      dead_r    <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      started_r <= started_nxt;
      neg_r     <= neg_nxt;
      dead_r    <= dead_nxt;
    end
  end

endmodule

// ===== hw/rtl/command_line_tokenizer.sv =====
// Top level of the command line tokenizer.
// Takes one text byte per transaction and splits each line into a command name
// and up to seven signed 32-bit decimal arguments separated by single spaces.
// A newline byte ends the line and produces one result transaction carrying
// the status, the packed name (first character in the lowest byte), the
// argument count and the argument values; on any fault only the status is
// nonzero. Bytes are taken at one per cycle while input ready is high: each byte
// is registered in the byte register, then applied to the line state and, for a
// newline, to the result register.
// Input ready drops only while a newline waits in the byte register and the
// previous result has not yet been taken.
module command_line_tokenizer import cltok_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cltok_in_if.sink    in_if,
  cltok_out_if.source out_if
);

  // Byte register
  logic       byte_vld_r;
  logic [7:0] byte_r;

  // Line state
  status_t          line_status_r, line_status_nxt;
  logic [TOK_W-1:0] token_index_r, token_index_nxt;
  logic             last_was_space_r, last_was_space_nxt;
  logic [LEN_W-1:0] line_length_r, line_length_nxt;
  logic [NLEN_W-1:0] name_length_r, name_length_nxt;
  logic [7:0]       name_store_r [NAME_LANES];
  logic [7:0]       name_store_nxt [NAME_LANES];
  logic [ACC_W-1:0] arg_store_r [ARG_LANES];
  logic [ACC_W-1:0] arg_view [ARG_LANES];

  // Result register
  logic             out_valid_r;
  status_t          out_status_r;
  logic [63:0]      out_name_low_r, out_name_high_r;
  logic [2:0]       out_arg_count_r;
  logic [ACC_W-1:0] out_args_r [ARG_LANES];

  // Byte decode and control
  logic             advance;
  logic             proc;
  logic             is_nl, is_sp, is_ws, is_plain;
  logic             len_fault, dbl_fault, range_fault, name_fault, many_fault;
  logic             name_wr, arg_wr;
  logic [TOK_W-1:0] slot;
  status_t          first_fault;
  num_cmd_t         num_cmd;
  num_res_t         num_res;

  // Handshake: stall only a newline that finds the result register full
  assign advance      = !byte_vld_r || !is_nl || !out_valid_r || out_if.ready;
  assign proc         = byte_vld_r && advance;
  assign in_if.ready  = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (advance) begin
      byte_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_if.valid) begin
      byte_r <= in_if.text_byte;
    end
  end

  // Byte classes
  always_comb begin
    case (byte_r) inside
      CH_TAB, CH_VT, CH_FF, CH_CR: is_ws = 1'b1;
      default:                     is_ws = 1'b0;
    endcase
  end

  assign is_nl    = (byte_r == CH_NL);
  assign is_sp    = (byte_r == CH_SP);
  assign is_plain = !is_nl && !is_sp && !is_ws;

  // Number parser
  assign num_cmd.close = proc && (is_nl || is_sp);
  assign num_cmd.feed  = proc && is_plain && (token_index_r != '0) && !many_fault;

  cltok_num u_num (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (num_cmd),
    .char_in (byte_r),
    .res     (num_res)
  );

  // Faults of this byte, in the order they are met
  assign len_fault   = !is_nl && (line_length_r >= LEN_W'(MAX_LINE - 1));
  assign dbl_fault   = (is_nl || is_sp) && last_was_space_r;
  assign range_fault = (is_nl || is_sp) && (token_index_r != '0) && num_res.range_err;
  assign name_fault  = is_plain && (token_index_r == '0)
                       && (name_length_r >= NLEN_W'(NAME_BYTES));
  assign many_fault  = is_plain && (token_index_r > TOK_W'(ARG_SLOTS));

  always_comb begin
    if (len_fault)                     first_fault = ST_LENGTH;
    else if (dbl_fault)                first_fault = ST_SPACING;
    else if (range_fault)              first_fault = ST_RANGE;
    else if (is_ws)                    first_fault = ST_SPACING;
    else if (name_fault || many_fault) first_fault = ST_LENGTH;
    else                               first_fault = ST_OK;
  end

  assign line_status_nxt = (line_status_r != ST_OK) ? line_status_r : first_fault;

  // Store writes
  assign slot    = token_index_r - TOK_W'(1);
  assign name_wr = is_plain && (token_index_r == '0) && !name_fault;
  assign arg_wr  = (is_nl || is_sp) && (token_index_r != '0) && num_res.live
                   && !num_res.range_err && (slot < TOK_W'(ARG_SLOTS));

  // Argument lanes with the closing token folded in
  always_comb begin
    for (int i = 0; i < ARG_LANES; i++) begin
      arg_view[i] = arg_store_r[i];
      if (arg_wr && (slot[ARG_IDX_W-1:0] == ARG_IDX_W'(i))) begin
        arg_view[i] = num_res.value;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NAME_LANES; i++) begin
      name_store_nxt[i] = name_store_r[i];
      if (name_wr && (name_length_r[3:0] == 4'(i))) begin
        name_store_nxt[i] = byte_r;
      end
    end
  end

  // Next line state for a non-newline byte
  always_comb begin
    line_length_nxt    = len_fault ? line_length_r : line_length_r + LEN_W'(1);
    token_index_nxt    = token_index_r;
    last_was_space_nxt = 1'b0;
    name_length_nxt    = name_wr ? name_length_r + NLEN_W'(1) : name_length_r;
    if (is_sp) begin
      last_was_space_nxt = 1'b1;
      if (token_index_r < TOK_MAX) begin
        token_index_nxt = token_index_r + TOK_W'(1);
      end
    end
  end

  // Line state registers, cleared at each newline
  always_ff @(posedge clk) begin
    if (!rst_n || (proc && is_nl)) begin
      line_status_r    <= ST_OK;
      token_index_r    <= '0;
      last_was_space_r <= 1'b0;
      line_length_r    <= '0;
      name_length_r    <= '0;
      for (int i = 0; i < NAME_LANES; i++) name_store_r[i] <= '0;
      for (int i = 0; i < ARG_LANES; i++)  arg_store_r[i]  <= '0;
    end else if (proc) begin
      line_status_r    <= line_status_nxt;
      token_index_r    <= token_index_nxt;
      last_was_space_r <= last_was_space_nxt;
      line_length_r    <= line_length_nxt;
      name_length_r    <= name_length_nxt;
      for (int i = 0; i < NAME_LANES; i++) name_store_r[i] <= name_store_nxt[i];
      for (int i = 0; i < ARG_LANES; i++)  arg_store_r[i]  <= arg_view[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && is_nl) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_nl) begin
      out_status_r <= line_status_nxt;
      for (int i = 0; i < 8; i++) begin
        out_name_low_r[8*i +: 8]  <= (line_status_nxt == ST_OK) ? name_store_r[i]   : 8'd0;
        out_name_high_r[8*i +: 8] <= (line_status_nxt == ST_OK) ? name_store_r[i+8] : 8'd0;
      end
      out_arg_count_r <= (line_status_nxt == ST_OK) ? token_index_r[2:0] : 3'd0;
      for (int i = 0; i < ARG_LANES; i++) begin
        out_args_r[i] <= (line_status_nxt == ST_OK) ? arg_view[i] : '0;
      end
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.name_low  = out_name_low_r;
  assign out_if.name_high = out_name_high_r;
  assign out_if.arg_count = out_arg_count_r;
  assign out_if.arg0      = $signed(out_args_r[0]);
  assign out_if.arg1      = $signed(out_args_r[1]);
  assign out_if.arg2      = $signed(out_args_r[2]);
  assign out_if.arg3      = $signed(out_args_r[3]);
  assign out_if.arg4      = $signed(out_args_r[4]);
  assign out_if.arg5      = $signed(out_args_r[5]);
  assign out_if.arg6      = $signed(out_args_r[6]);

  // Checks
  a_fault_zeroes_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |->
      (out_name_low_r == '0) && (out_name_high_r == '0) && (out_arg_count_r == '0))
    else $error("faulted result carries payload");

  a_stall_only_on_newline: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> byte_vld_r && is_nl && out_valid_r && !out_if.ready)
    else $error("input stalled without a pending newline");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    proc && is_nl |=> (token_index_r == '0) && (line_length_r == '0)
                      && (line_status_r == ST_OK) && out_valid_r)
    else $error("line state not cleared after newline");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_length_r <= LEN_W'(MAX_LINE - 1))
    else $error("line length beyond limit");

endmodule

// ===== test/tb_command_line_tokenizer.sv =====
// Testbench of the command line tokenizer: byte stream stimulus and line-by-line result checking.
`timescale 1ns / 1ps

module tb_command_line_tokenizer;
  import cltok_pkg::*;

  // One parsed line as it appears on the result channel
  typedef struct packed {
    status_t                        status;
    logic [63:0]                    name_low;
    logic [63:0]                    name_high;
    logic [2:0]                     arg_count;
    logic [ARG_LANES-1:0][31:0]     args;
  } line_result_t;

  // Tracks the line being typed and the parsed lines still owed by the block
  class line_scoreboard;
    line_result_t pending_lines[$];
    int           errors;

    status_t      first_fault;
    logic [3:0]   spaces;
    logic         after_space;
    logic [6:0]   line_bytes;
    logic [7:0]   name_chars [NAME_LANES];
    logic [4:0]   name_len;
    logic [31:0]  arg_vals [ARG_LANES];
    logic [63:0]  magnitude;
    logic         started;
    logic         negative;
    logic         digits_done;

    function new();
      errors = 0;
      start_line();
    endfunction

    function void start_line();
      first_fault = ST_OK;
      spaces      = '0;
      after_space = 1'b0;
      line_bytes  = '0;
      name_len    = '0;
      magnitude   = '0;
      started     = 1'b0;
      negative    = 1'b0;
      digits_done = 1'b0;
      foreach (name_chars[i]) name_chars[i] = '0;
      foreach (arg_vals[i]) arg_vals[i] = '0;
    endfunction

    // Only the first fault of a line counts
    function void flag(status_t code);
      if (first_fault == ST_OK) first_fault = code;
    endfunction

    // A token ends: store the argument or flag a range fault
    function void close_token();
      logic [63:0] limit;
      int          slot;
      if (spaces != 0 && started) begin
        slot  = spaces - 1;
        limit = negative ? NEG_LIMIT : POS_LIMIT;
        if (magnitude > limit) flag(ST_RANGE);
        else if (slot < ARG_SLOTS)
          arg_vals[slot] = negative ? -magnitude[31:0] : magnitude[31:0];
      end
      magnitude   = '0;
      started     = 1'b0;
      negative    = 1'b0;
      digits_done = 1'b0;
    endfunction

    // Signed decimal read: optional sign, then digits up to the first non-digit
    function void feed_arg(logic [7:0] b);
      logic [63:0] nxt;
      if (spaces > ARG_SLOTS) begin
        flag(ST_LENGTH);
        return;
      end
      if (!started) begin
        started = 1'b1;
        if (b == CH_PLUS) return;
        if (b == CH_MINUS) begin
          negative = 1'b1;
          return;
        end
      end
      if (!digits_done && b >= CH_ZERO && b <= CH_NINE) begin
        nxt       = magnitude * 10 + (b - CH_ZERO);
        magnitude = (nxt > ACC_CAP) ? ACC_CAP : nxt;
      end else begin
        digits_done = 1'b1;
      end
    endfunction

    // Called for each byte the block accepts
    function void note_byte(logic [7:0] b);
      line_result_t r;
      if (b == CH_NL) begin
        if (after_space) flag(ST_SPACING);
        close_token();
        r = '0;
        r.status = first_fault;
        if (first_fault == ST_OK) begin
          for (int i = 0; i < 8; i++) begin
            r.name_low[8*i +: 8]  = name_chars[i];
            r.name_high[8*i +: 8] = name_chars[i+8];
          end
          r.arg_count = spaces[2:0];
          for (int i = 0; i < ARG_LANES; i++) r.args[i] = arg_vals[i];
        end
        pending_lines.push_back(r);
        start_line();
        return;
      end

      if (line_bytes >= MAX_LINE - 1) flag(ST_LENGTH);
      else line_bytes++;

      if (b == CH_SP) begin
        if (after_space) flag(ST_SPACING);
        close_token();
        if (spaces < TOK_MAX) spaces++;
        after_space = 1'b1;
        return;
      end

      after_space = 1'b0;
      if (b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR) begin
        flag(ST_SPACING);
        return;
      end

      if (spaces == 0) begin
        if (name_len < NAME_BYTES) begin
          name_chars[name_len] = b;
          name_len++;
        end else begin
          flag(ST_LENGTH);
        end
      end else begin
        feed_arg(b);
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
        errors++;
      end
    endfunction

    // Called for each result transaction
    function void check_line(line_result_t got);
      line_result_t want;
      if (pending_lines.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending_lines.pop_front();
      compare("status", want.status, got.status);
      compare("name_low", want.name_low, got.name_low);
      compare("name_high", want.name_high, got.name_high);
      compare("arg_count", want.arg_count, got.arg_count);
      for (int i = 0; i < ARG_LANES; i++)
        compare($sformatf("arg%0d", i), want.args[i], got.args[i]);
    endfunction

    function int pending();
      return pending_lines.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cltok_in_if  in_ch();
  cltok_out_if out_ch();

  command_line_tokenizer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  line_scoreboard sb;
  logic [7:0]     line_q[$];
  bit             no_idle;
  bit             hold_request;
  int             bytes_sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic transmit_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    send_byte(CH_NL);
    line_q.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    line_q.delete();
    add_text(s);
    transmit_line();
  endtask

  // Line with one raw byte between two text parts
  task automatic send_with(string head, logic [7:0] mid, string tail);
    line_q.delete();
    add_text(head);
    line_q.push_back(mid);
    add_text(tail);
    transmit_line();
  endtask

  // Lowercase mostly, otherwise any byte that is not a separator
  function automatic logic [7:0] random_name_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    do c = 8'($urandom_range(0, 255)); while (c == CH_SP || (c >= CH_TAB && c <= CH_CR));
    return c;
  endfunction

  // One argument token, boundary values and junk suffixes included
  task automatic add_random_arg();
    logic [63:0] mag;
    case ($urandom_range(0, 7))
      0:       mag = $urandom_range(0, 9);
      1:       mag = $urandom_range(0, 99999);
      2:       mag = $urandom();
      3:       mag = 64'd2147483646 + $urandom_range(0, 4);
      4:       mag = {$urandom(), $urandom()};
      default: mag = $urandom_range(0, 999);
    endcase
    case ($urandom_range(0, 3))
      0, 1: line_q.push_back(CH_MINUS);
      2:    line_q.push_back(CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) begin
      // no digits at all
      if ($urandom_range(0, 1) == 0) line_q.push_back(random_name_char());
      return;
    end
    if ($urandom_range(0, 7) == 0) add_text("00");
    add_text($sformatf("%0d", mag));
    if ($urandom_range(0, 7) == 0) begin
      line_q.push_back(random_name_char());
      if ($urandom_range(0, 1) == 0) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Mostly well-formed command lines, some noise and overlong lines
  task automatic random_line();
    int         nargs;
    int         pos;
    logic [7:0] c;
    line_q.delete();
    case ($urandom_range(0, 9))
      7, 8: begin
        repeat ($urandom_range(0, 20)) begin
          if ($urandom_range(0, 3) == 0) c = CH_SP;
          else do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
          line_q.push_back(c);
        end
      end
      9: begin
        add_text("L ");
        repeat ($urandom_range(94, 99)) line_q.push_back(CH_ZERO);
      end
      default: begin
        nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 9) : $urandom_range(0, 7);
        if ($urandom_range(0, 7) == 0) begin
          // leading space: the name stays empty
          line_q.push_back(CH_SP);
          add_random_arg();
        end else begin
          repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 17) : $urandom_range(1, 8))
            line_q.push_back(random_name_char());
        end
        repeat (nargs) begin
          line_q.push_back(CH_SP);
          add_random_arg();
        end
        // occasional stray separator, possibly at the end
        if ($urandom_range(0, 7) == 0) begin
          pos = $urandom_range(0, line_q.size());
          c   = CH_TAB + 8'($urandom_range(0, 4));
          if (c == CH_NL) c = CH_SP;
          line_q.insert(pos, c);
        end
      end
    endcase
    transmit_line();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    line_result_t got;
    int           stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        stall = draw_wait();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      got.status    = out_ch.status;
      got.name_low  = out_ch.name_low;
      got.name_high = out_ch.name_high;
      got.arg_count = out_ch.arg_count;
      got.args[0]   = out_ch.arg0;
      got.args[1]   = out_ch.arg1;
      got.args[2]   = out_ch.arg2;
      got.args[3]   = out_ch.arg3;
      got.args[4]   = out_ch.arg4;
      got.args[5]   = out_ch.arg5;
      got.args[6]   = out_ch.arg6;
      sb.check_line(got);
    end
  end

  // Byte side and run control
  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    rst_n           <= 1'b0;
    sb           = new();
    no_idle      = 1'b0;
    hold_request = 1'b0;
    bytes_sent   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines
    send_text("");
    send_text("go 1 -2 +3");
    send_text(" 5 -6");
    send_text("a  b");
    send_text("ab ");
    send_with("a", CH_TAB, "b");
    send_with("x", CH_VT, "1");
    send_with("", CH_FF, "");
    send_with("cr", CH_CR, "");
    send_text("abcdefghijklmnop 1");
    send_text("abcdefghijklmnopq");
    send_text("c 1 2 3 4 5 6 7");
    send_text("c 1 2 3 4 5 6 7 8");
    send_text("s 1 2 3 4 5 6 7 8 9 10 11 12 13 14 15 16");
    send_text("v 2147483647 -2147483648 +0 -0");
    send_text("v 2147483648");
    send_text("v -2147483649");
    send_text("v 99999999999999999999");
    send_text("v 12ab 3x4 - + abc --5 7-");
    // fault order: spacing before range, range before spacing, range before trailing space
    send_with("p", CH_TAB, "q 99999999999");
    send_with("p 99999999999 ", CH_TAB, "");
    send_text("p 99999999999 ");
    // zero byte and top-bit bytes in the name
    send_with("", 8'h00, "\200\377 4");
    // line length just inside and just over the limit
    line_q.delete();
    add_text("L ");
    repeat (MAX_LINE - 3) line_q.push_back(CH_ZERO);
    transmit_line();
    line_q.delete();
    add_text("L ");
    repeat (MAX_LINE - 2) line_q.push_back(CH_ZERO);
    transmit_line();
    wait_drained();

    // Random lines: early long hold-off with back-to-back bytes, then a drain
    for (int k = 0; bytes_sent < 900; k++) begin
      no_idle = (k < 6) || (k % 10 >= 8);
      if (k == 1) hold_request = 1'b1;
      if (k == 6) wait_drained();
      random_line();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
